/* hdl/sws_pkg.sv */
// shared types and constants for the sliding window shuffle buffer
// no dependencies
package sws_pkg;

    localparam int BUCKET_SIZE_DEF = 256;
    localparam int NUM_BUCKETS_DEF = 16;
    localparam logic [31:0] SEED_RESET = 32'd1;

    localparam logic [1:0] KIND_HEAD  = 2'd0;
    localparam logic [1:0] KIND_TAIL  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    localparam logic [2:0] ST_ITEM     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_OK       = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] bound;
    } t_request;

    typedef struct packed {
        logic [31:0] item;
        logic [2:0]  status;
    } t_result;

endpackage

/* hdl/sliding_window_shuffle_buffer.sv */
// sliding window shuffle buffer top level
// depends on sws_pkg
// A request is taken while busy is low and start is high; exactly one result follows
// on o_strobe for one cycle, and busy is low in that cycle. The receiver cannot hold a
// result off. A tail request steps through the dropped buckets one by one. A head
// request appends one index per step and opens new buckets as needed, bounded by
// the bucket ring. Each draw of a fetch does the multiply, walks up to NUM_BUCKETS
// bucket counts, then does the read, read and write-back on the
// single-port item memory; draws that land below the tail repeat, and a fetch that
// runs out of items ends with an empty status. The configuration channel is ready only
// when idle.
module sliding_window_shuffle_buffer #(
    parameter int BUCKET_SIZE = sws_pkg::BUCKET_SIZE_DEF,
    parameter int NUM_BUCKETS = sws_pkg::NUM_BUCKETS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sws_pkg::t_request i_request,
    output logic              busy,
    output logic              o_strobe,
    output sws_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    input  logic [31:0]       i_cfg_data,
    output logic              o_cfg_ready
);

    localparam int DEPTH   = NUM_BUCKETS * BUCKET_SIZE;
    localparam int SLOT_W  = $clog2(NUM_BUCKETS);
    localparam int USED_W  = $clog2(NUM_BUCKETS + 1);
    localparam int FILL_W  = $clog2(BUCKET_SIZE + 1);
    localparam int ITEMS_W = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = SLOT_W + 1;
    localparam int PROD_W  = 32 + ITEMS_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_TAIL  = 8'b0000_0100,
        S_DRAW  = 8'b0000_1000,
        S_WALK  = 8'b0001_0000,
        S_RDA   = 8'b0010_0000,
        S_RDB   = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    t_state               r_state;
    logic [31:0]          r_mem [DEPTH];
    logic [31:0]          r_rd;
    logic [31:0]          r_upper [NUM_BUCKETS];
    logic [FILL_W-1:0]    r_fill [NUM_BUCKETS];
    logic [SLOT_W-1:0]    r_front;
    logic [USED_W-1:0]    r_used;
    logic [31:0]          r_head;
    logic [31:0]          r_tail;
    logic [ITEMS_W-1:0]   r_items;
    logic [31:0]          r_rng;
    logic [31:0]          r_bound;
    logic [ITEMS_W-1:0]   r_pos;
    logic [USED_W-1:0]    r_k;
    logic [ADDR_W-1:0]    r_addr_pos;
    logic [ADDR_W-1:0]    r_addr_last;
    logic [31:0]          r_got;
    logic                 r_strobe;
    sws_pkg::t_result     r_result;

    logic [31:0]          n_rng;
    logic [PROD_W-1:0]    prod;
    logic [SLOT_W-1:0]    last_slot;
    logic [SLOT_W-1:0]    new_slot;
    logic [SLOT_W-1:0]    walk_slot;
    logic [ADDR_W-1:0]    mem_ra;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [31:0]          mem_wd;
    logic [ADDR_W-1:0]    last_base;
    logic [ADDR_W-1:0]    walk_base;
    logic [ITEMS_W-1:0]   walk_fill;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
                                                  input logic [USED_W-1:0] k);
        logic [SUM_W:0] s;
        s = (SUM_W+1)'(front) + (SUM_W+1)'(k);
        if (s >= (SUM_W+1)'(NUM_BUCKETS)) begin
            s = s - (SUM_W+1)'(NUM_BUCKETS);
        end
        return SLOT_W'(s);
    endfunction

    always_comb begin
        n_rng = r_rng ^ (r_rng << 13);
        n_rng = n_rng ^ (n_rng >> 17);
        n_rng = n_rng ^ (n_rng << 5);
    end

    assign prod      = PROD_W'(n_rng) * PROD_W'(r_items);
    assign last_slot = slot_of(r_front, r_used - USED_W'(1));
    assign new_slot  = slot_of(r_front, r_used);
    assign walk_slot = slot_of(r_front, r_k);
    assign last_base = ADDR_W'(32'(last_slot) * BUCKET_SIZE);
    assign walk_base = ADDR_W'(32'(walk_slot) * BUCKET_SIZE);
    assign walk_fill = ITEMS_W'(r_fill[walk_slot]);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr_pos;
        mem_wd = r_rd;
        mem_ra = (r_state == S_RDB) ? r_addr_last : r_addr_pos;
        if (r_state == S_HEAD && r_head != r_bound && r_used != '0
                && r_fill[last_slot] < FILL_W'(BUCKET_SIZE)) begin
            mem_we = 1'b1;
            mem_wa = last_base + ADDR_W'(r_fill[last_slot]);
            mem_wd = r_head;
        end else if (r_state == S_WB) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_used   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_items  <= '0;
            r_rng    <= sws_pkg::SEED_RESET;
            r_strobe <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_rng <= i_cfg_data;
                    end
                    if (start) begin
                        r_bound           <= i_request.bound;
                        r_result.item     <= '0;
                        case (i_request.kind)
                            sws_pkg::KIND_HEAD: begin
                                if (i_request.bound < r_head) begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= sws_pkg::ST_REJECT;
                                end else begin
                                    r_state <= S_HEAD;
                                end
                            end
                            sws_pkg::KIND_TAIL: begin
                                if (i_request.bound < r_tail) begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= sws_pkg::ST_REJECT;
                                end else if (i_request.bound >= r_head) begin
                                    r_tail          <= i_request.bound;
                                    r_head          <= i_request.bound;
                                    r_used          <= '0;
                                    r_items         <= '0;
                                    r_strobe        <= 1'b1;
                                    r_result.status <= sws_pkg::ST_OK;
                                end else begin
                                    r_tail  <= i_request.bound;
                                    r_state <= S_TAIL;
                                end
                            end
                            sws_pkg::KIND_FETCH: begin
                                r_state <= S_DRAW;
                            end
                            default: begin
                                r_strobe        <= 1'b1;
                                r_result.status <= sws_pkg::ST_EMPTY;
                            end
                        endcase
                    end
                end
                S_HEAD: begin
                    if (r_head == r_bound) begin
                        r_strobe        <= 1'b1;
                        r_result.status <= sws_pkg::ST_OK;
                        r_state         <= S_IDLE;
                    end else if (r_used == '0
                            || r_fill[last_slot] >= FILL_W'(BUCKET_SIZE)) begin
                        if (r_used >= USED_W'(NUM_BUCKETS)) begin
                            r_strobe        <= 1'b1;
                            r_result.status <= sws_pkg::ST_OVERFLOW;
                            r_state         <= S_IDLE;
                        end else begin
                            r_fill[new_slot]  <= '0;
                            r_upper[new_slot] <= r_head;
                            r_used            <= r_used + USED_W'(1);
                        end
                    end else begin
                        r_fill[last_slot]  <= r_fill[last_slot] + FILL_W'(1);
                        r_items            <= r_items + ITEMS_W'(1);
                        r_head             <= r_head + 32'd1;
                        r_upper[last_slot] <= r_head + 32'd1;
                    end
                end
                S_TAIL: begin
                    if (r_used != '0 && r_upper[r_front] <= r_tail) begin
                        r_items         <= r_items - ITEMS_W'(r_fill[r_front]);
                        r_fill[r_front] <= '0;
                        r_front         <= (r_front == SLOT_W'(NUM_BUCKETS - 1))
                                           ? '0 : r_front + SLOT_W'(1);
                        r_used          <= r_used - USED_W'(1);
                    end else begin
                        r_strobe        <= 1'b1;
                        r_result.status <= sws_pkg::ST_OK;
                        r_state         <= S_IDLE;
                    end
                end
                S_DRAW: begin
                    if (r_items == '0) begin
                        r_strobe        <= 1'b1;
                        r_result.item   <= '0;
                        r_result.status <= sws_pkg::ST_EMPTY;
                        r_state         <= S_IDLE;
                    end else begin
                        r_rng   <= n_rng;
                        r_pos   <= ITEMS_W'(prod >> 32);
                        r_items <= r_items - ITEMS_W'(1);
                        r_k     <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_k >= r_used) begin
                        r_state <= S_DRAW;
                    end else if (r_pos < walk_fill) begin
                        r_fill[walk_slot] <= r_fill[walk_slot] - FILL_W'(1);
                        r_addr_pos        <= walk_base + ADDR_W'(r_pos);
                        r_addr_last       <= walk_base + ADDR_W'(r_fill[walk_slot])
                                             - ADDR_W'(1);
                        r_state           <= S_RDA;
                    end else begin
                        r_pos <= r_pos - walk_fill;
                        r_k   <= r_k + USED_W'(1);
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_got   <= r_rd;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_got >= r_tail) begin
                        r_strobe        <= 1'b1;
                        r_result.item   <= r_got;
                        r_result.status <= sws_pkg::ST_ITEM;
                        r_state         <= S_IDLE;
                    end else begin
                        r_state <= S_DRAW;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !$past(!i_rst_n) |-> $past(r_state) != S_DRAW
            || $past(r_items) == '0)
        else $error("result strobe from a draw with items left");

    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items <= ITEMS_W'(DEPTH))
        else $error("item count beyond capacity");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(NUM_BUCKETS))
        else $error("bucket ring overused");

    a_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_result.status != sws_pkg::ST_ITEM |-> r_result.item == '0)
        else $error("nonzero item without item status");

endmodule

/* tb/sliding_window_shuffle_buffer_tb.sv */
// self-checking testbench for the sliding window shuffle buffer
// depends on sws_pkg and the sliding_window_shuffle_buffer rtl
// a behavioral copy of the buffer predicts each result, a monitor checks them in order
module sliding_window_shuffle_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BSIZE = sws_pkg::BUCKET_SIZE_DEF;
    localparam int NBKT = sws_pkg::NUM_BUCKETS_DEF;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam longint CYCLE_LIMIT = 50000000;
    localparam logic [31:0] MAXV = 32'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    sws_pkg::t_request i_request = '0;
    logic busy;
    logic o_strobe;
    sws_pkg::t_result o_result;
    logic i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic o_cfg_ready;

    sliding_window_shuffle_buffer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_request(i_request),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // buffer model state
    logic [31:0] idx_store [NBKT*BSIZE];
    logic [31:0] bkt_upper [NBKT];
    logic [8:0]  bkt_fill [NBKT];
    logic [3:0]  front;
    logic [4:0]  used;
    logic [31:0] head_mark, tail_mark, rng;
    logic [12:0] held;

    sws_pkg::t_result pending_results[$];
    int mismatches = 0;
    longint cycles = 0;
    bit long_gaps;

    function automatic logic [3:0] slot(int k);
        return 4'((int'(front) + k) % NBKT);
    endfunction

    function automatic logic [31:0] xorshift();
        logic [31:0] x;
        x = rng;
        x ^= x << 13;
        x ^= x >> 17;
        x ^= x << 5;
        rng = x;
        return x;
    endfunction

    function automatic logic [2:0] grow_head(logic [31:0] b);
        logic [3:0] last;
        logic [31:0] n, room;
        if (b < head_mark) return sws_pkg::ST_REJECT;
        while (head_mark < b) begin
            if (used == 0 || bkt_fill[slot(used - 1)] >= BSIZE) begin
                if (used >= NBKT) return sws_pkg::ST_OVERFLOW;
                last = slot(used);
                used++;
                bkt_fill[last] = 0;
                bkt_upper[last] = head_mark;
            end
            last = slot(used - 1);
            room = BSIZE - bkt_fill[last];
            n = b - head_mark;
            if (n > room) n = room;
            for (int i = 0; i < n; i++)
                idx_store[last*BSIZE + bkt_fill[last] + i] = head_mark + i;
            bkt_fill[last] += 9'(n);
            held += 13'(n);
            head_mark += n;
            bkt_upper[last] = head_mark;
        end
        return sws_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] grow_tail(logic [31:0] b);
        if (b < tail_mark) return sws_pkg::ST_REJECT;
        tail_mark = b;
        if (b >= head_mark) begin
            head_mark = b;
            used = 0;
            held = 0;
            return sws_pkg::ST_OK;
        end
        while (used > 0 && bkt_upper[front] <= tail_mark) begin
            held -= 13'(bkt_fill[front]);
            bkt_fill[front] = 0;
            front++;
            used--;
        end
        return sws_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] draw_index(output logic [31:0] got);
        logic [63:0] prod;
        logic [31:0] pos, v;
        logic [3:0] b;
        bit found;
        got = 0;
        while (held > 0) begin
            prod = 64'(xorshift()) * 64'(held);
            pos = prod[63:32];
            held--;
            found = 0;
            v = 0;
            for (int k = 0; k < used && !found; k++) begin
                b = slot(k);
                if (pos < bkt_fill[b]) begin
                    v = idx_store[b*BSIZE + pos];
                    bkt_fill[b]--;
                    idx_store[b*BSIZE + pos] = idx_store[b*BSIZE + bkt_fill[b]];
                    idx_store[b*BSIZE + bkt_fill[b]] = v;
                    found = 1;
                end else begin
                    pos -= bkt_fill[b];
                end
            end
            if (found && v >= tail_mark) begin
                got = v;
                return sws_pkg::ST_ITEM;
            end
        end
        return sws_pkg::ST_EMPTY;
    endfunction

    function automatic sws_pkg::t_result predict_result(sws_pkg::t_request r);
        sws_pkg::t_result res;
        logic [31:0] got;
        res = '0;
        case (r.kind)
            sws_pkg::KIND_HEAD: res.status = grow_head(r.bound);
            sws_pkg::KIND_TAIL: res.status = grow_tail(r.bound);
            sws_pkg::KIND_FETCH: begin
                res.status = draw_index(got);
                res.item = got;
            end
            default: res.status = sws_pkg::ST_EMPTY;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] d);
        return (a > MAXV - d) ? MAXV : a + d;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sliding_window_shuffle_buffer: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        sws_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item=%h status=%0d",
                             o_result.item, o_result.status);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.item !== want.item || o_result.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp item=%h status=%0d got item=%h status=%0d",
                                 want.item, want.status, o_result.item, o_result.status);
                end
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic [31:0] bound);
        sws_pkg::t_request r;
        int gap;
        r.kind = kind;
        r.bound = bound;
        start <= 1'b1;
        i_request <= r;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_result(r));
        gap = 0;
        if (long_gaps) begin
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 60);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [31:0] seed);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        rng = seed;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        long_gaps = 0;
        write_seed(32'd0);
        send_request(sws_pkg::KIND_FETCH, 32'd0);
        send_request(KIND_NONE, MAXV);
        send_request(sws_pkg::KIND_HEAD, 32'd0);
        send_request(sws_pkg::KIND_HEAD, 32'd10);
        send_request(sws_pkg::KIND_FETCH, 32'd0);
        send_request(sws_pkg::KIND_FETCH, 32'd0);
        send_request(sws_pkg::KIND_HEAD, 32'd10);
        send_request(sws_pkg::KIND_TAIL, 32'd5);
        repeat (6) send_request(sws_pkg::KIND_FETCH, 32'd0);
        send_request(sws_pkg::KIND_TAIL, 32'd3);
        send_request(sws_pkg::KIND_HEAD, 32'd4);
        send_request(sws_pkg::KIND_HEAD, 32'd300);
        send_request(sws_pkg::KIND_TAIL, 32'd300);
        send_request(sws_pkg::KIND_HEAD, 32'd5300);
        send_request(sws_pkg::KIND_FETCH, 32'd0);
        send_request(sws_pkg::KIND_TAIL, 32'd600);
        send_request(sws_pkg::KIND_HEAD, 32'd5400);
        drain();
    endtask

    task automatic test_random(int count);
        logic [31:0] b;
        longint span;
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) long_gaps = $urandom_range(0, 3) != 0;
            if (i == count / 2) drain();
            pick = $urandom_range(0, 99);
            span = longint'(head_mark) - longint'(tail_mark);
            if (pick < 30) begin
                send_request(sws_pkg::KIND_HEAD, sat_add(head_mark, $urandom_range(0, 300)));
            end else if (pick < 45) begin
                b = tail_mark + 32'(longint'($urandom) % (span + 1));
                send_request(sws_pkg::KIND_TAIL, b);
            end else if (pick < 88) begin
                send_request(sws_pkg::KIND_FETCH, $urandom);
            end else if (pick < 93) begin
                b = (head_mark == 0) ? 32'd0 : head_mark - $urandom_range(1, 50);
                send_request($urandom_range(0, 1) ? sws_pkg::KIND_HEAD : sws_pkg::KIND_TAIL,
                             b);
            end else if (pick < 95) begin
                send_request(KIND_NONE, $urandom);
            end else if (pick < 98) begin
                send_request(sws_pkg::KIND_HEAD, $urandom);
            end else begin
                send_request(sws_pkg::KIND_TAIL, $urandom);
            end
        end
        drain();
    endtask

    task automatic test_top_of_range();
        long_gaps = 0;
        send_request(sws_pkg::KIND_TAIL, MAXV);
        send_request(sws_pkg::KIND_HEAD, MAXV);
        send_request(sws_pkg::KIND_HEAD, 32'd0);
        send_request(sws_pkg::KIND_FETCH, 32'd0);
        drain();
    endtask

    initial begin
        rng = sws_pkg::SEED_RESET;
        front = 0;
        used = 0;
        head_mark = 0;
        tail_mark = 0;
        held = 0;
        for (int i = 0; i < NBKT; i++) bkt_fill[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_seed(MAXV);
        test_random(600);
        write_seed($urandom | 32'd1);
        test_random(600);
        write_seed(sws_pkg::SEED_RESET);
        test_random(520);
        test_top_of_range();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("sliding_window_shuffle_buffer: match");
        else
            $display("sliding_window_shuffle_buffer: mismatch");
        $finish;
    end
endmodule
